>>> src/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Widths, types and sequencer states for the sliding window statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package sws_pkg;

    localparam int SAMPLE_W             = 16;
    localparam int SUM_W                = 20;
    localparam int AVG_W                = 24;
    localparam int FILL_W               = 5;
    localparam int FRAC_W               = 8;
    localparam int DIV_W                = SUM_W + FRAC_W;
    localparam int DIV_CNT_W            = $clog2(DIV_W);
    localparam int DEFAULT_WINDOW_DEPTH = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic signed [AVG_W-1:0]    avg_t;
    typedef logic        [FILL_W-1:0]   fill_t;

    localparam sample_t SAMPLE_MAX = sample_t'(32767);
    localparam sample_t SAMPLE_MIN = sample_t'(-32768);
    localparam avg_t    AVG_MAX    = avg_t'(8388607);
    localparam avg_t    AVG_MIN    = avg_t'(-8388608);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_WRITE,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } sws_state_t;

endpackage : sws_pkg

`default_nettype wire

>>> src/sws_in_if.sv
// ----------------------------------------------------------------------------
// sws_in_if
// Sample channel: valid/ready handshake carrying one signed sample per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sws_in_if
    import sws_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface : sws_in_if

`default_nettype wire

>>> src/sws_out_if.sv
// ----------------------------------------------------------------------------
// sws_out_if
// Statistics channel: valid/ready handshake carrying one window result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sws_out_if
    import sws_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t latest;
    sum_t    window_sum;
    avg_t    average_q8;
    sample_t maximum;
    sample_t minimum;
    fill_t   fill_count;

    modport source (
        output valid, output latest, output window_sum, output average_q8,
        output maximum, output minimum, output fill_count, input ready
    );
    modport sink (
        input valid, input latest, input window_sum, input average_q8,
        input maximum, input minimum, input fill_count, output ready
    );
endinterface : sws_out_if

`default_nettype wire

>>> src/sliding_window_stats.sv
// ----------------------------------------------------------------------------
// sliding_window_stats
// Moving sum/average with window minimum and maximum over a sample ring.
// ----------------------------------------------------------------------------
// Each sample beat yields one result beat: the sample, the sum of the last
// WINDOW_DEPTH samples, their mean in Q8 (truncated toward zero), the window
// max/min and the fill count. One sample is processed at a time. From
// accept to result, a sample passes through these steps in order: drop the
// oldest sample once the window is full, write the ring, run the min/max
// scan through the single registered ring read port, run the bit-serial
// restoring divide of sum*256 by the fill count and load the output
// register, plus any wait for that register to free up. Once the load is
// done the block returns to idle and can take the next sample, while the
// previous result may still wait on the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_stats
    import sws_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
)(
    input  logic         clk,
    input  logic         rst_n,
    sws_in_if.sink       samples,
    sws_out_if.source    stats
);

    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int REM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0]     LAST_PTR = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]     FULL_CNT = CNT_W'(WINDOW_DEPTH);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);
    localparam logic [DIV_W-1:0]     POS_LIMIT = DIV_W'(8388607);
    localparam logic [DIV_W-1:0]     NEG_LIMIT = DIV_W'(8388608);

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    // sequencer and window state
    sws_state_t           state_reg, state_next;
    sample_t              sample_reg, sample_next;
    logic [PTR_W-1:0]     oldest_reg, oldest_next;
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]     held_reg, held_next;
    sum_t                 sum_reg, sum_next;

    // scan
    logic [PTR_W-1:0]     scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0]     issued_reg, issued_next;
    logic                 pend_reg, pend_next;
    sample_t              hi_reg, hi_next;
    sample_t              lo_reg, lo_next;

    // divider
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic                 neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    sample_t              latest_reg, latest_next;
    sum_t                 wsum_reg, wsum_next;
    avg_t                 avg_reg, avg_next;
    sample_t              max_reg, max_next;
    sample_t              min_reg, min_next;
    fill_t                fill_reg, fill_next;

    // ring memory
    sample_t              ring_mem [WINDOW_DEPTH];
    sample_t              rd_data_reg;
    logic [PTR_W-1:0]     rd_addr;
    logic                 wr_en;

    logic                 accept;
    logic                 scan_done;
    logic                 div_done;
    logic                 out_load;
    logic [SUM_W-1:0]     sum_abs;
    logic [REM_W-1:0]     rem_sh;
    logic [DIV_W-1:0]     quo_sh;
    logic [REM_W-1:0]     divisor;
    logic [DIV_W-1:0]     quo_neg;

    assign accept    = samples.valid && samples.ready;
    assign scan_done = !pend_reg && (issued_reg == held_reg);
    assign div_done  = (div_cnt_reg == DIV_LAST);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || stats.ready);
    assign sum_abs   = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign rem_sh    = {rem_reg[REM_W-2:0], quo_reg[DIV_W-1]};
    assign quo_sh    = {quo_reg[DIV_W-2:0], 1'b0};
    assign divisor   = REM_W'(held_reg);
    assign quo_neg   = ~quo_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_ptr_reg] <= sample_reg;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (held_reg == FULL_CNT) ? ST_DROP : ST_WRITE;
                end
            end
            ST_DROP:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        samples.ready    = (state_reg == ST_IDLE);
        wr_en            = (state_reg == ST_WRITE);
        rd_addr          = (state_reg == ST_IDLE) ? oldest_reg : scan_ptr_reg;
        stats.valid      = out_valid_reg;
        stats.latest     = latest_reg;
        stats.window_sum = wsum_reg;
        stats.average_q8 = avg_reg;
        stats.maximum    = max_reg;
        stats.minimum    = min_reg;
        stats.fill_count = fill_reg;
    end

    // datapath
    always_comb
    begin
        sample_next    = sample_reg;
        oldest_next    = oldest_reg;
        wr_ptr_next    = wr_ptr_reg;
        held_next      = held_reg;
        sum_next       = sum_reg;
        scan_ptr_next  = scan_ptr_reg;
        issued_next    = issued_reg;
        pend_next      = pend_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        latest_next    = latest_reg;
        wsum_next      = wsum_reg;
        avg_next       = avg_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        fill_next      = fill_reg;

        if (out_valid_reg && stats.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sample_next = samples.sample;
                end
            end
            ST_DROP:
            begin
                // rd_data_reg holds the oldest entry, read on the accept cycle
                sum_next    = sum_reg - SUM_W'(rd_data_reg);
                oldest_next = advance(oldest_reg);
                held_next   = FULL_CNT - 1'b1;
            end
            ST_WRITE:
            begin
                wr_ptr_next   = advance(wr_ptr_reg);
                held_next     = held_reg + 1'b1;
                sum_next      = sum_reg + SUM_W'(sample_reg);
                scan_ptr_next = oldest_reg;
                issued_next   = '0;
                pend_next     = 1'b0;
                hi_next       = SAMPLE_MIN;
                lo_next       = SAMPLE_MAX;
            end
            ST_SCAN:
            begin
                // read issue runs one entry ahead of the compare
                pend_next = (issued_reg != held_reg);
                if (issued_reg != held_reg)
                begin
                    scan_ptr_next = advance(scan_ptr_reg);
                    issued_next   = issued_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (rd_data_reg > hi_reg)
                    begin
                        hi_next = rd_data_reg;
                    end
                    if (rd_data_reg < lo_reg)
                    begin
                        lo_next = rd_data_reg;
                    end
                end
                if (scan_done)
                begin
                    neg_next     = sum_reg[SUM_W-1];
                    quo_next     = {sum_abs, {FRAC_W{1'b0}}};
                    rem_next     = '0;
                    div_cnt_next = '0;
                end
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                quo_next = quo_sh;
                rem_next = rem_sh;
                if (rem_sh >= divisor)
                begin
                    rem_next    = rem_sh - divisor;
                    quo_next[0] = 1'b1;
                end
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    latest_next    = sample_reg;
                    wsum_next      = sum_reg;
                    max_next       = hi_reg;
                    min_next       = lo_reg;
                    fill_next      = FILL_W'(held_reg);
                    priority if (!neg_reg && (quo_reg > POS_LIMIT))
                    begin
                        avg_next = AVG_MAX;
                    end
                    else if (neg_reg && (quo_reg > NEG_LIMIT))
                    begin
                        avg_next = AVG_MIN;
                    end
                    else
                    begin
                        avg_next = neg_reg ? AVG_W'(quo_neg) : AVG_W'(quo_reg);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            wr_ptr_reg    <= '0;
            held_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            issued_reg    <= '0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            wr_ptr_reg    <= wr_ptr_next;
            held_reg      <= held_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            issued_reg    <= issued_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        scan_ptr_reg <= scan_ptr_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        latest_reg   <= latest_next;
        wsum_reg     <= wsum_next;
        avg_reg      <= avg_next;
        max_reg      <= max_next;
        min_reg      <= min_next;
        fill_reg     <= fill_next;
    end

endmodule : sliding_window_stats

`default_nettype wire

>>> src/sws_checker.sv
// ----------------------------------------------------------------------------
// sws_checker
// Port-level checks on the statistics channel of sliding_window_stats.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_checker
    import sws_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire sample_t latest,
    input wire sample_t maximum,
    input wire sample_t minimum,
    input wire fill_t   fill_count
);

    // a stalled result beat stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(latest) && $stable(fill_count))
        else $error("stats beat dropped or changed while stalled");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fill_count != '0)
        else $error("result with empty window");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> minimum <= maximum)
        else $error("window minimum above maximum");

    // the newest sample is always inside the window
    a_latest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (minimum <= latest) && (latest <= maximum))
        else $error("latest sample outside window min/max");

endmodule : sws_checker

bind sliding_window_stats sws_checker u_sws_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (stats.valid),
    .out_ready  (stats.ready),
    .latest     (stats.latest),
    .maximum    (stats.maximum),
    .minimum    (stats.minimum),
    .fill_count (stats.fill_count)
);

`default_nettype wire
